// ===== sv/cpli_pkg.sv =====
// ----------------------------------------------------------------------------
// cpli_pkg
// Shared types, codes and helpers for the convex polygon / line intersect block.
// ----------------------------------------------------------------------------
package cpli_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_COORD_BITS   = 24;

    localparam int IN_COORD_W = 24;
    localparam int COEF_W     = 24;
    localparam int COEFC_W    = 48;
    localparam int OUT_IDX_W  = 10;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 48;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] CONTACT_NONE  = 2'd0;
    localparam logic [1:0] CONTACT_CROSS = 2'd1;
    localparam logic [1:0] CONTACT_TOUCH = 2'd2;

    // width of a*x + b*y + c with the coefficients possibly negated
    function automatic int val_width(input int cb);
        int p;
        p = COEF_W + 1 + cb;
        return ((p > COEFC_W + 1) ? p : COEFC_W + 1) + 2;
    endfunction

    typedef struct packed {
        logic load;
        logic start;
    } ev_req_t;

    typedef enum logic [1:0] {
        EV_IDLE,
        EV_MX,
        EV_MY,
        EV_SUM
    } ev_state_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EXT_INIT,
        ST_EXT_TEST,
        ST_EXT_DIV,
        ST_EXT_P1,
        ST_EXT_W1,
        ST_EXT_P2,
        ST_EXT_W2,
        ST_EXT_E0,
        ST_EXT_F0,
        ST_EXT_E1,
        ST_EXT_F1,
        ST_EXT_E2,
        ST_EXT_F2,
        ST_DECIDE,
        ST_CR_INIT,
        ST_CR_TEST,
        ST_CR_P,
        ST_CR_W,
        ST_CR_END,
        ST_TCH_P1,
        ST_TCH_W1,
        ST_TCH_P2,
        ST_TCH_W2,
        ST_FIN
    } ctrl_state_t;

endpackage

// ===== sv/cpli_ram.sv =====
// ----------------------------------------------------------------------------
// cpli_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cpli_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/cpli_eval.sv =====
// ----------------------------------------------------------------------------
// cpli_eval
// Line value unit: a*x + b*y + c over one shared multiplier.
// ----------------------------------------------------------------------------
module cpli_eval
    import cpli_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  ev_req_t                                 req,
    input  logic signed [COEF_W-1:0]                coef_a,
    input  logic signed [COEF_W-1:0]                coef_b,
    input  logic signed [COEFC_W-1:0]               coef_c,
    input  logic [2*COORD_BITS-1:0]                 rdata,
    output logic                                    done,
    output logic signed [val_width(COORD_BITS)-1:0] value
);

    localparam int VAL_W  = val_width(COORD_BITS);
    localparam int PROD_W = COEF_W + 1 + COORD_BITS;

    ev_state_t state_reg, state_next;

    logic signed [COEF_W:0]      a_reg, b_reg;
    logic signed [COEFC_W:0]     c_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [VAL_W-1:0]     acc_reg, val_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic                        done_reg;
    logic signed [COEF_W:0]      mul_a;
    logic signed [COORD_BITS-1:0] mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic signed [COEF_W:0]      a_ext, b_ext;
    logic signed [COEFC_W:0]     c_ext;

    assign a_ext = (COEF_W + 1)'(coef_a);
    assign b_ext = (COEF_W + 1)'(coef_b);
    assign c_ext = (COEFC_W + 1)'(coef_c);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            EV_IDLE: if (req.start) state_next = EV_MX;
            EV_MX:   state_next = EV_MY;
            EV_MY:   state_next = EV_SUM;
            EV_SUM:  state_next = EV_IDLE;
            default: state_next = EV_IDLE;
        endcase
    end

    // y is taken from the read data captured with x
    always_comb
    begin
        mul_a = b_reg;
        mul_b = y_reg;
        if (state_reg == EV_MX)
        begin
            mul_a = a_reg;
            mul_b = signed'(rdata[COORD_BITS-1:0]);
        end
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == EV_SUM);
        end
    end

    always_ff @(posedge clk)
    begin
        // coefficients flip sign together when b is negative
        if (req.load)
        begin
            a_reg <= coef_b[COEF_W-1] ? -a_ext : a_ext;
            b_reg <= coef_b[COEF_W-1] ? -b_ext : b_ext;
            c_reg <= coef_b[COEF_W-1] ? -c_ext : c_ext;
        end
        case (state_reg)
            EV_MX:
            begin
                prod_reg <= mul_p;
                y_reg    <= signed'(rdata[2*COORD_BITS-1:COORD_BITS]);
            end
            EV_MY:
            begin
                acc_reg  <= VAL_W'(prod_reg) + VAL_W'(c_reg);
                prod_reg <= mul_p;
            end
            EV_SUM:
            begin
                val_reg <= acc_reg + VAL_W'(prod_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign done  = done_reg;
    assign value = val_reg;

endmodule

// ===== sv/cpli_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpli_ctrl
// Sequencer: polygon loading, ternary extreme searches, binary crossing
// searches, touch checks and the result register.
// ----------------------------------------------------------------------------
module cpli_ctrl
    import cpli_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_BITS   = DEF_COORD_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [1:0]                              op,
    input  logic signed [IN_COORD_W-1:0]            vx,
    input  logic signed [IN_COORD_W-1:0]            vy,
    output ev_req_t                                 ev_req,
    input  logic                                    ev_done,
    input  logic signed [val_width(COORD_BITS)-1:0] ev_value,
    output logic                                    ram_we,
    output logic [$clog2(MAX_VERTICES)-1:0]         ram_waddr,
    output logic [2*COORD_BITS-1:0]                 ram_wdata,
    output logic [$clog2(MAX_VERTICES)-1:0]         ram_raddr,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [1:0]                              out_contact,
    output logic [2:0]                              out_count,
    output logic [OUT_IDX_W-1:0]                    out_idx0,
    output logic [OUT_IDX_W-1:0]                    out_idx1,
    output logic [OUT_IDX_W-1:0]                    out_idx2,
    output logic [OUT_IDX_W-1:0]                    out_idx3
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int EXT_W = CNT_W + 1;
    localparam int VAL_W = val_width(COORD_BITS);
    localparam int DIV_S = EXT_W + 1;
    localparam logic [EXT_W-1:0] DIV_M = EXT_W'(((2 ** DIV_S) + 2) / 3);

    ctrl_state_t state_reg, state_next;

    logic [CNT_W-1:0]             total_reg, total_next;
    logic [IDX_W-1:0]             left_reg, left_next, right_reg, right_next;
    logic signed [COORD_BITS-1:0] least_reg, least_next, great_reg, great_next;

    logic                    mx_reg, mx_next;
    logic [EXT_W-1:0]        s_reg, s_next, f_reg, f_next, q_reg, q_next;
    logic signed [VAL_W-1:0] va_reg, va_next, vb_reg, vb_next;
    logic [IDX_W-1:0]        imax_reg, imax_next, imin_reg, imin_next;
    logic signed [VAL_W-1:0] vmax_reg, vmax_next, vmin_reg, vmin_next;
    logic                    side_reg, side_next;
    logic [IDX_W-1:0]        ra0_reg, ra0_next, ra1_reg, ra1_next;
    logic [IDX_W-1:0]        rb0_reg, rb0_next, rb1_reg, rb1_next;
    logic                    twoa_reg, twoa_next, twob_reg, twob_next;
    logic [IDX_W-1:0]        te_reg, te_next;

    logic [1:0]       pc_reg, pc_next;
    logic [2:0]       pn_reg, pn_next;
    logic [IDX_W-1:0] p0_reg, p0_next, p1_reg, p1_next;
    logic [IDX_W-1:0] p2_reg, p2_next, p3_reg, p3_next;

    logic             ov_reg, ov_next;
    logic [1:0]       oc_reg;
    logic [2:0]       on_reg;
    logic [IDX_W-1:0] o0_reg, o1_reg, o2_reg, o3_reg;
    logic             out_load;

    logic                         accept;
    logic signed [COORD_BITS-1:0] x_c, y_c;
    logic                         room;
    logic [2*EXT_W-1:0]           div_prod;
    logic [EXT_W:0]               mid_sum;
    logic [EXT_W-1:0]             mid;
    logic [EXT_W-1:0]             ev_ext;
    logic [EXT_W-1:0]             n_ext;
    logic [IDX_W-1:0]             ev_idx;

    function automatic logic [IDX_W-1:0] wrap(input logic [EXT_W-1:0] v,
                                              input logic [EXT_W-1:0] n);
        logic [EXT_W-1:0] r;
        r = (v >= n) ? v - n : v;
        return r[IDX_W-1:0];
    endfunction

    function automatic logic opposite(input logic signed [VAL_W-1:0] p,
                                      input logic signed [VAL_W-1:0] q);
        return (p < 0 && q > 0) || (p > 0 && q < 0);
    endfunction

    function automatic logic better(input logic want_max,
                                    input logic signed [VAL_W-1:0] p,
                                    input logic signed [VAL_W-1:0] q);
        return want_max ? (p >= q) : (p <= q);
    endfunction

    assign accept   = in_valid && in_ready;
    assign x_c      = COORD_BITS'(vx);
    assign y_c      = COORD_BITS'(vy);
    assign room     = total_reg < CNT_W'(MAX_VERTICES);
    assign n_ext    = EXT_W'(total_reg);
    assign div_prod = (2*EXT_W)'(f_reg - s_reg) * (2*EXT_W)'(DIV_M);
    assign mid_sum  = (EXT_W + 1)'(s_reg) + (EXT_W + 1)'(f_reg);
    assign mid      = mid_sum[EXT_W:1];
    assign out_load = (state_reg == ST_FIN) && (!ov_reg || out_ready);

    // next state and sequencer registers
    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        left_next  = left_reg;
        right_next = right_reg;
        least_next = least_reg;
        great_next = great_reg;
        mx_next    = mx_reg;
        s_next     = s_reg;
        f_next     = f_reg;
        q_next     = q_reg;
        va_next    = va_reg;
        vb_next    = vb_reg;
        imax_next  = imax_reg;
        imin_next  = imin_reg;
        vmax_next  = vmax_reg;
        vmin_next  = vmin_reg;
        side_next  = side_reg;
        ra0_next   = ra0_reg;
        ra1_next   = ra1_reg;
        rb0_next   = rb0_reg;
        rb1_next   = rb1_reg;
        twoa_next  = twoa_reg;
        twob_next  = twob_reg;
        te_next    = te_reg;
        pc_next    = pc_reg;
        pn_next    = pn_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        p3_next    = p3_reg;
        ov_next    = ov_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_CLEAR:
                        begin
                            total_next = '0;
                            left_next  = '0;
                            right_next = '0;
                            least_next = '0;
                            great_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (room)
                            begin
                                if (total_reg == '0)
                                begin
                                    least_next = x_c;
                                    great_next = x_c;
                                    left_next  = '0;
                                    right_next = '0;
                                end
                                else
                                begin
                                    if (x_c > great_reg)
                                    begin
                                        great_next = x_c;
                                        right_next = total_reg[IDX_W-1:0];
                                    end
                                    if (x_c < least_reg)
                                    begin
                                        least_next = x_c;
                                        left_next  = total_reg[IDX_W-1:0];
                                    end
                                end
                                total_next = total_reg + 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            pc_next = CONTACT_NONE;
                            pn_next = '0;
                            p0_next = '0;
                            p1_next = '0;
                            p2_next = '0;
                            p3_next = '0;
                            mx_next = 1'b1;
                            if (total_reg == '0)
                            begin
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                state_next = ST_EXT_INIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EXT_INIT:
            begin
                // max runs rightmost to leftmost, min leftmost to rightmost
                s_next = EXT_W'(mx_reg ? right_reg : left_reg);
                f_next = EXT_W'(mx_reg ? left_reg : right_reg);
                if ((mx_reg ? right_reg : left_reg) > (mx_reg ? left_reg : right_reg))
                begin
                    f_next = EXT_W'(mx_reg ? left_reg : right_reg) + n_ext;
                end
                state_next = ST_EXT_TEST;
            end
            ST_EXT_TEST:
            begin
                state_next = (f_reg - s_reg > EXT_W'(2)) ? ST_EXT_DIV : ST_EXT_E0;
            end
            ST_EXT_DIV:
            begin
                q_next     = EXT_W'(div_prod >> DIV_S);
                state_next = ST_EXT_P1;
            end
            ST_EXT_P1: state_next = ST_EXT_W1;
            ST_EXT_W1:
            begin
                if (ev_done)
                begin
                    va_next    = ev_value;
                    state_next = ST_EXT_P2;
                end
            end
            ST_EXT_P2: state_next = ST_EXT_W2;
            ST_EXT_W2:
            begin
                if (ev_done)
                begin
                    if (mx_reg ? (va_reg < ev_value) : (va_reg > ev_value))
                    begin
                        s_next = s_reg + q_reg;
                    end
                    else
                    begin
                        f_next = f_reg - q_reg;
                    end
                    state_next = ST_EXT_TEST;
                end
            end
            ST_EXT_E0: state_next = ST_EXT_F0;
            ST_EXT_F0:
            begin
                if (ev_done)
                begin
                    va_next    = ev_value;
                    state_next = ST_EXT_E1;
                end
            end
            ST_EXT_E1: state_next = ST_EXT_F1;
            ST_EXT_F1:
            begin
                if (ev_done)
                begin
                    vb_next    = ev_value;
                    state_next = ST_EXT_E2;
                end
            end
            ST_EXT_E2: state_next = ST_EXT_F2;
            ST_EXT_F2:
            begin
                if (ev_done)
                begin
                    logic [IDX_W-1:0]        ci;
                    logic signed [VAL_W-1:0] cv;
                    if (better(mx_reg, va_reg, vb_reg))
                    begin
                        if (better(mx_reg, va_reg, ev_value))
                        begin
                            ci = wrap(s_reg, n_ext);
                            cv = va_reg;
                        end
                        else
                        begin
                            ci = wrap(f_reg, n_ext);
                            cv = ev_value;
                        end
                    end
                    else if (better(mx_reg, vb_reg, ev_value))
                    begin
                        ci = wrap(s_reg + 1'b1, n_ext);
                        cv = vb_reg;
                    end
                    else
                    begin
                        ci = wrap(f_reg, n_ext);
                        cv = ev_value;
                    end
                    if (mx_reg)
                    begin
                        imax_next  = ci;
                        vmax_next  = cv;
                        mx_next    = 1'b0;
                        state_next = ST_EXT_INIT;
                    end
                    else
                    begin
                        imin_next  = ci;
                        vmin_next  = cv;
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                if (opposite(vmax_reg, vmin_reg))
                begin
                    side_next  = 1'b0;
                    state_next = ST_CR_INIT;
                end
                else if (vmax_reg == '0)
                begin
                    te_next    = imax_reg;
                    state_next = ST_TCH_P1;
                end
                else if (vmin_reg == '0)
                begin
                    te_next    = imin_reg;
                    state_next = ST_TCH_P1;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_CR_INIT:
            begin
                // end values are the extremes already known
                s_next  = EXT_W'(side_reg ? imin_reg : imax_reg);
                f_next  = EXT_W'(side_reg ? imax_reg : imin_reg);
                va_next = side_reg ? vmin_reg : vmax_reg;
                vb_next = side_reg ? vmax_reg : vmin_reg;
                if ((side_reg ? imin_reg : imax_reg) > (side_reg ? imax_reg : imin_reg))
                begin
                    f_next = EXT_W'(side_reg ? imax_reg : imin_reg) + n_ext;
                end
                state_next = ST_CR_TEST;
            end
            ST_CR_TEST:
            begin
                if (f_reg - s_reg > EXT_W'(1))
                begin
                    state_next = ST_CR_P;
                end
                else
                begin
                    if (side_reg)
                    begin
                        rb0_next  = wrap(s_reg, n_ext);
                        rb1_next  = wrap(f_reg, n_ext);
                        twob_next = 1'b1;
                    end
                    else
                    begin
                        ra0_next  = wrap(s_reg, n_ext);
                        ra1_next  = wrap(f_reg, n_ext);
                        twoa_next = 1'b1;
                    end
                    state_next = ST_CR_END;
                end
            end
            ST_CR_P: state_next = ST_CR_W;
            ST_CR_W:
            begin
                if (ev_done)
                begin
                    if (opposite(ev_value, va_reg))
                    begin
                        f_next     = mid;
                        vb_next    = ev_value;
                        state_next = ST_CR_TEST;
                    end
                    else if (opposite(ev_value, vb_reg))
                    begin
                        s_next     = mid;
                        va_next    = ev_value;
                        state_next = ST_CR_TEST;
                    end
                    else
                    begin
                        // probe vertex lies on the line
                        if (side_reg)
                        begin
                            rb0_next  = wrap(mid, n_ext);
                            twob_next = 1'b0;
                        end
                        else
                        begin
                            ra0_next  = wrap(mid, n_ext);
                            twoa_next = 1'b0;
                        end
                        state_next = ST_CR_END;
                    end
                end
            end
            ST_CR_END:
            begin
                if (!side_reg)
                begin
                    side_next  = 1'b1;
                    state_next = ST_CR_INIT;
                end
                else
                begin
                    logic             swap, t1, t2;
                    logic [IDX_W-1:0] l10, l11, l20, l21;
                    swap = !twoa_reg && twob_reg;
                    t1   = swap ? twob_reg : twoa_reg;
                    t2   = swap ? twoa_reg : twob_reg;
                    l10  = swap ? rb0_reg : ra0_reg;
                    l11  = swap ? rb1_reg : ra1_reg;
                    l20  = swap ? ra0_reg : rb0_reg;
                    l21  = swap ? ra1_reg : rb1_reg;
                    pc_next = CONTACT_CROSS;
                    pn_next = 3'd2 + 3'(t1) + 3'(t2);
                    p0_next = l10;
                    if (t1)
                    begin
                        p1_next = l11;
                        p2_next = l20;
                        p3_next = t2 ? l21 : '0;
                    end
                    else
                    begin
                        p1_next = l20;
                        p2_next = t2 ? l21 : '0;
                        p3_next = '0;
                    end
                    state_next = ST_FIN;
                end
            end
            ST_TCH_P1: state_next = ST_TCH_W1;
            ST_TCH_W1:
            begin
                if (ev_done)
                begin
                    pc_next = CONTACT_TOUCH;
                    p0_next = te_reg;
                    if (ev_value == '0)
                    begin
                        pn_next    = 3'd2;
                        p1_next    = wrap(EXT_W'(te_reg) + 1'b1, n_ext);
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        pn_next    = 3'd1;
                        state_next = ST_TCH_P2;
                    end
                end
            end
            ST_TCH_P2: state_next = ST_TCH_W2;
            ST_TCH_W2:
            begin
                if (ev_done)
                begin
                    if (ev_value == '0)
                    begin
                        pn_next = 3'd2;
                        p1_next = wrap(EXT_W'(te_reg) + n_ext - 1'b1, n_ext);
                    end
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        ev_req.load  = accept && (op == OP_QUERY);
        ev_req.start = 1'b0;
        ev_ext       = s_reg;
        case (state_reg)
            ST_EXT_P1:
            begin
                ev_req.start = 1'b1;
                ev_ext       = s_reg + q_reg;
            end
            ST_EXT_P2:
            begin
                ev_req.start = 1'b1;
                ev_ext       = f_reg - q_reg;
            end
            ST_EXT_E0:
            begin
                ev_req.start = 1'b1;
                ev_ext       = s_reg;
            end
            ST_EXT_E1:
            begin
                ev_req.start = 1'b1;
                ev_ext       = s_reg + 1'b1;
            end
            ST_EXT_E2:
            begin
                ev_req.start = 1'b1;
                ev_ext       = f_reg;
            end
            ST_CR_P:
            begin
                ev_req.start = 1'b1;
                ev_ext       = mid;
            end
            ST_TCH_P1:
            begin
                ev_req.start = 1'b1;
                ev_ext       = EXT_W'(te_reg) + 1'b1;
            end
            ST_TCH_P2:
            begin
                ev_req.start = 1'b1;
                ev_ext       = EXT_W'(te_reg) + n_ext - 1'b1;
            end
            default:
            begin
            end
        endcase
        ev_idx    = wrap(ev_ext, n_ext);
        ram_raddr = ev_idx;
        ram_we    = accept && (op == OP_APPEND) && room;
        ram_waddr = total_reg[IDX_W-1:0];
        ram_wdata = {y_c, x_c};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            left_reg  <= '0;
            right_reg <= '0;
            least_reg <= '0;
            great_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            least_reg <= least_next;
            great_reg <= great_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg   <= mx_next;
        s_reg    <= s_next;
        f_reg    <= f_next;
        q_reg    <= q_next;
        va_reg   <= va_next;
        vb_reg   <= vb_next;
        imax_reg <= imax_next;
        imin_reg <= imin_next;
        vmax_reg <= vmax_next;
        vmin_reg <= vmin_next;
        side_reg <= side_next;
        ra0_reg  <= ra0_next;
        ra1_reg  <= ra1_next;
        rb0_reg  <= rb0_next;
        rb1_reg  <= rb1_next;
        twoa_reg <= twoa_next;
        twob_reg <= twob_next;
        te_reg   <= te_next;
        pc_reg   <= pc_next;
        pn_reg   <= pn_next;
        p0_reg   <= p0_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        p3_reg   <= p3_next;
        if (out_load)
        begin
            oc_reg <= pc_reg;
            on_reg <= pn_reg;
            o0_reg <= p0_reg;
            o1_reg <= p1_reg;
            o2_reg <= p2_reg;
            o3_reg <= p3_reg;
        end
    end

    assign out_valid   = ov_reg;
    assign out_contact = oc_reg;
    assign out_count   = on_reg;
    assign out_idx0    = OUT_IDX_W'(o0_reg);
    assign out_idx1    = OUT_IDX_W'(o1_reg);
    assign out_idx2    = OUT_IDX_W'(o2_reg);
    assign out_idx3    = OUT_IDX_W'(o3_reg);

endmodule

// ===== sv/convex_polygon_line_intersect.sv =====
// ----------------------------------------------------------------------------
// convex_polygon_line_intersect
// Convex polygon store with line crossing and touching queries.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries requests: s_axis_tuser is the op (clear, append, query),
//   s_axis_tdata holds vertex x, y and line coefficients a, b, c.
//   clear and append give no result; append beyond capacity is dropped.
//   each query gives one result on m_axis: contact, hit count and up to
//   four vertex indices.
//   a query runs two ternary searches and up to two binary searches, all
//   through one line value unit: every vertex probe is a registered memory
//   read, two passes of the shared multiplier and the final add.
//   s_axis_tready is low while a query runs.
//   the result sits in an output register; a stalled receiver holds it while
//   the next request is taken, and a following query waits only at its end.
//   reset empties the polygon; memory contents need no clearing pass.
// ----------------------------------------------------------------------------
module convex_polygon_line_intersect
    import cpli_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_BITS   = DEF_COORD_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // vertex_x, vertex_y, coef_a, coef_b, coef_c
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // contact, hit_count, index_0, index_1, index_2, index_3, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int VAL_W = val_width(COORD_BITS);

    ev_req_t                 ev_req;
    logic                    ev_done;
    logic signed [VAL_W-1:0] ev_value;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr, ram_raddr;
    logic [2*COORD_BITS-1:0] ram_wdata, ram_rdata;
    logic [1:0]              contact;
    logic [2:0]              hit_count;
    logic [OUT_IDX_W-1:0]    index_0, index_1, index_2, index_3;

    cpli_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cpli_eval #(
        .COORD_BITS (COORD_BITS)
    ) u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ev_req),
        .coef_a (s_axis_tdata[71:48]),
        .coef_b (s_axis_tdata[95:72]),
        .coef_c (s_axis_tdata[143:96]),
        .rdata  (ram_rdata),
        .done   (ev_done),
        .value  (ev_value)
    );

    cpli_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .op          (s_axis_tuser),
        .vx          (s_axis_tdata[23:0]),
        .vy          (s_axis_tdata[47:24]),
        .ev_req      (ev_req),
        .ev_done     (ev_done),
        .ev_value    (ev_value),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_contact (contact),
        .out_count   (hit_count),
        .out_idx0    (index_0),
        .out_idx1    (index_1),
        .out_idx2    (index_2),
        .out_idx3    (index_3)
    );

    assign m_axis_tdata = {3'b000, index_3, index_2, index_1, index_0, hit_count, contact};

endmodule

// ===== sv/cpli_checker.sv =====
// ----------------------------------------------------------------------------
// cpli_checker
// Port level checks for the convex polygon / line intersect block.
// ----------------------------------------------------------------------------
module cpli_checker
    import cpli_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [1:0]            s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [1:0] contact;
    logic [2:0] hits;

    assign contact = m_axis_tdata[1:0];
    assign hits    = m_axis_tdata[4:2];

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a query blocks further requests
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_QUERY |=> !s_axis_tready)
        else $error("request taken during query");

    a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && contact == CONTACT_NONE |-> hits == 3'd0)
        else $error("indices without contact");

    a_cross_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && contact == CONTACT_CROSS |-> hits == 3'd2 || hits == 3'd3 ||
        hits == 3'd4)
        else $error("bad crossing count");

    a_touch_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && contact == CONTACT_TOUCH |-> hits == 3'd1 || hits == 3'd2)
        else $error("bad touch count");

endmodule

bind convex_polygon_line_intersect cpli_checker u_cpli_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
